/* rtl/ptas_pkg.sv */
// Shared types, constants and coefficient table of the turning angle sum unit.
`default_nettype none
package ptas_pkg;

    localparam int unsigned COORD_W        = 32;
    localparam int unsigned DIFF_W         = 33;
    localparam int unsigned CI_W           = 20;
    localparam int unsigned ROT_W          = 32;
    localparam int unsigned MAX_POINTS_DEF = 4096;
    localparam int unsigned MAX_CURVES_DEF = 1048576;
    localparam int unsigned FIFO_DEPTH     = 2;

    localparam logic [ROT_W-1:0]  THRESH_RESET = 32'd823550;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;

    // One point's worth of work handed from the front to the back.
    typedef struct packed {
        logic [5:0][DIFF_W-1:0] d;        // a.x a.y a.z b.x b.y b.z
        logic                   do_angle;
        logic                   last;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_VLOAD,
        S_NORM,
        S_SQ,
        S_SQACC,
        S_SQRT,
        S_DIVINIT,
        S_DIV,
        S_DIVEND,
        S_DOT,
        S_DOTACC,
        S_COS,
        S_HMUL,
        S_HADD,
        S_RMUL,
        S_RFIN,
        S_FINISH
    } seq_state_t;

    // Q30 coefficients of the arccosine polynomial.
    function automatic logic signed [32:0] acos_coef(input logic [2:0] k);
        logic signed [32:0] c;
        case (k)
            3'd0:    c = 33'sd1686629690;
            3'd1:    c = -33'sd230423709;
            3'd2:    c = 33'sd95540460;
            3'd3:    c = -33'sd53874249;
            3'd4:    c = 33'sd33169905;
            3'd5:    c = -33'sd18348235;
            3'd6:    c = 33'sd7161955;
            default: c = -33'sd1355590;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/ptas_fifo.sv */
// Short job queue between the point front end and the angle engine.
`default_nettype none
module ptas_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  ptas_pkg::job_t      wr_data,
    input  wire logic           rd_en,
    output ptas_pkg::job_t      rd_data,
    output logic                is_full,
    output logic                is_empty
);
    import ptas_pkg::*;

    localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    job_t              mem [FIFO_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign is_full  = (count_reg == (AW+1)'(FIFO_DEPTH));
    assign is_empty = (count_reg == '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/ptas_front.sv */
// Point front end: holds the two previous points and forms the segment vectors.
`default_nettype none
module ptas_front #(
    parameter int unsigned MAX_POINTS = ptas_pkg::MAX_POINTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic signed [31:0]   coord_x,
    input  wire logic signed [31:0]   coord_y,
    input  wire logic signed [31:0]   coord_z,
    input  wire logic                 last_point,
    output ptas_pkg::job_t            job
);
    import ptas_pkg::*;

    localparam int unsigned PW = $clog2(MAX_POINTS);

    logic signed [COORD_W-1:0] cin       [3];
    logic signed [COORD_W-1:0] p0_reg    [3];
    logic signed [COORD_W-1:0] p1_reg    [3];
    logic [PW-1:0]             seen_reg, seen_next;

    assign cin[0] = coord_x;
    assign cin[1] = coord_y;
    assign cin[2] = coord_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            job.d[i]   = {p1_reg[i][COORD_W-1], p1_reg[i]} - {p0_reg[i][COORD_W-1], p0_reg[i]};
            job.d[3+i] = {cin[i][COORD_W-1], cin[i]} - {p1_reg[i][COORD_W-1], p1_reg[i]};
        end
        job.do_angle = (seen_reg >= PW'(2));
        job.last     = last_point;
    end

    // Saturate the point count; it only gates when angles start.
    always_comb
    begin
        seen_next = seen_reg;
        if (last_point)
        begin
            seen_next = '0;
        end
        else if (seen_reg != PW'(MAX_POINTS - 1))
        begin
            seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= '0;
                p1_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            seen_reg <= seen_next;
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i] <= last_point ? '0 : p1_reg[i];
                p1_reg[i] <= last_point ? '0 : cin[i];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ptas_back.sv */
// Angle engine: serial unit vectors, dot product, arccosine and curve results.
`default_nettype none
module ptas_back #(
    parameter int unsigned MAX_CURVES = ptas_pkg::MAX_CURVES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  ptas_pkg::job_t      job,
    input  wire logic           job_valid,
    output logic                job_pop,
    input  wire logic [31:0]    threshold,
    input  wire logic           pop,
    output logic                empty,
    output logic [19:0]         curve_index,
    output logic [31:0]         total_rotation,
    output logic                is_interesting
);
    import ptas_pkg::*;

    localparam int unsigned CW = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;

    seq_state_t                state_reg, state_next;

    logic [5:0][DIFF_W-1:0]    d_reg;
    logic                      last_reg;
    logic                      vec_reg;
    logic [1:0]                idx_reg;
    logic [4:0]                cnt_reg;
    logic [DIFF_W-1:0]         mag_reg [3];
    logic                      sgn_reg [3];
    logic [DIFF_W-1:0]         m_reg;
    logic [63:0]               acc_reg;
    logic [63:0]               sq_n_reg, sq_res_reg, sq_bit_reg;
    logic                      sq_acos_reg;
    logic [31:0]               len_reg;
    logic [31:0]               rem_reg;
    logic [30:0]               dq_reg;
    logic signed [32:0]        ua_reg [3];
    logic signed [32:0]        ub_reg [3];
    logic signed [63:0]        dot_reg;
    logic                      cneg_reg;
    logic [30:0]               x_reg;
    logic signed [32:0]        p_reg;
    logic [2:0]                k_reg;
    logic signed [65:0]        prod_reg;
    logic [31:0]               sum_reg;
    logic [CW-1:0]             cc_reg;
    logic                      out_valid_reg;
    logic [19:0]               out_index_reg;
    logic [31:0]               out_rot_reg;
    logic                      out_int_reg;

    // combinational helpers
    logic [DIFF_W-1:0]         vmag [3];
    logic                      vsgn [3];
    logic [DIFF_W-1:0]         vmax;
    logic signed [32:0]        mul_a, mul_b;
    logic [63:0]               sq_t, sq_n_step, sq_res_step;
    logic                      sq_ge;
    logic [31:0]               dv_t;
    logic                      dv_ge;
    logic signed [65:0]        qm_full;
    logic signed [35:0]        qm;
    logic signed [63:0]        dot_adj;
    logic signed [33:0]        cval, cclamp;
    logic signed [35:0]        r_val;
    logic [21:0]               ang;
    logic [32:0]               sum_wide;
    logic                      out_free;
    logic signed [32:0]        u_new;
    logic [CW+19:0]            cc_ext;

    assign out_free = !out_valid_reg || pop;

    // Magnitudes and signs of the vector being normalized.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vsgn[i] = vec_reg ? d_reg[3+i][DIFF_W-1] : d_reg[i][DIFF_W-1];
            vmag[i] = vec_reg ? (vsgn[i] ? -d_reg[3+i] : d_reg[3+i])
                              : (vsgn[i] ? -d_reg[i] : d_reg[i]);
        end
        vmax = vmag[0];
        if (vmag[1] > vmax)
        begin
            vmax = vmag[1];
        end
        if (vmag[2] > vmax)
        begin
            vmax = vmag[2];
        end
    end

    // One square-root step: one result bit per cycle.
    always_comb
    begin
        sq_t        = sq_res_reg + sq_bit_reg;
        sq_ge       = (sq_n_reg >= sq_t);
        sq_n_step   = sq_ge ? (sq_n_reg - sq_t) : sq_n_reg;
        sq_res_step = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
    end

    // One restoring divide step.
    always_comb
    begin
        dv_t  = {rem_reg[30:0], dq_reg[30]};
        dv_ge = (dv_t >= len_reg);
        u_new = sgn_reg[idx_reg] ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg});
    end

    // Q30 product truncated toward zero, cosine, final angle and saturating sum.
    always_comb
    begin
        qm_full  = (prod_reg + (prod_reg[65] ? 66'sd1073741823 : 66'sd0)) >>> 30;
        qm       = qm_full[35:0];
        dot_adj  = dot_reg + (dot_reg[63] ? 64'sd1073741823 : 64'sd0);
        cval     = 34'(dot_adj >>> 30);
        if (cval > 34'sd1073741824)
        begin
            cclamp = 34'sd1073741824;
        end
        else if (cval < -34'sd1073741824)
        begin
            cclamp = -34'sd1073741824;
        end
        else
        begin
            cclamp = cval;
        end
        r_val = cneg_reg ? (PI_Q30 - qm) : qm;
        if (r_val < 0)
        begin
            r_val = '0;
        end
        ang      = 22'((36'(r_val) + 36'd8192) >> 14);
        sum_wide = {1'b0, sum_reg} + {11'b0, ang};
        cc_ext   = {20'b0, cc_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.do_angle ? S_VLOAD : S_FINISH;
                end
            end
            S_VLOAD:   state_next = (vmax == '0) ? S_FINISH : S_NORM;
            S_NORM:
            begin
                if (m_reg[DIFF_W-1:30] == '0 && m_reg[29])
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:      state_next = S_SQACC;
            S_SQACC:   state_next = (idx_reg == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT:
            begin
                if (sq_bit_reg[0])
                begin
                    state_next = sq_acos_reg ? S_RMUL : S_DIVINIT;
                end
            end
            S_DIVINIT: state_next = S_DIV;
            S_DIV:     state_next = (cnt_reg == 5'd30) ? S_DIVEND : S_DIV;
            S_DIVEND:
            begin
                if (idx_reg != 2'd2)
                begin
                    state_next = S_DIVINIT;
                end
                else
                begin
                    state_next = vec_reg ? S_DOT : S_VLOAD;
                end
            end
            S_DOT:     state_next = S_DOTACC;
            S_DOTACC:  state_next = (idx_reg == 2'd2) ? S_COS : S_DOT;
            S_COS:     state_next = S_HMUL;
            S_HMUL:    state_next = S_HADD;
            S_HADD:    state_next = (k_reg == 3'd0) ? S_SQRT : S_HMUL;
            S_RMUL:    state_next = S_RFIN;
            S_RFIN:    state_next = S_FINISH;
            S_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer: queue pop and multiplier operands
    always_comb
    begin
        job_pop = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_IDLE:  job_pop = job_valid;
            S_SQ:
            begin
                mul_a = $signed(mag_reg[idx_reg]);
                mul_b = $signed(mag_reg[idx_reg]);
            end
            S_DOT:
            begin
                mul_a = ua_reg[idx_reg];
                mul_b = ub_reg[idx_reg];
            end
            S_HMUL:
            begin
                mul_a = p_reg;
                mul_b = $signed({2'b00, x_reg});
            end
            S_RMUL:
            begin
                mul_a = p_reg;
                mul_b = $signed({1'b0, sq_res_reg[31:0]});
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_RFIN)
            begin
                sum_reg <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
            end
            // Emit the finished curve and start the next one.
            if (state_reg == S_FINISH && last_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                cc_reg        <= (cc_reg == CW'(MAX_CURVES - 1)) ? '0 : cc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_FINISH && last_reg && out_free)
        begin
            out_index_reg <= cc_ext[19:0];
            out_rot_reg   <= sum_reg;
            out_int_reg   <= (sum_reg > threshold);
        end
        case (state_reg)
            S_IDLE:
            begin
                d_reg    <= job.d;
                last_reg <= job.last;
                vec_reg  <= 1'b0;
            end
            S_VLOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= vmag[i];
                    sgn_reg[i] <= vsgn[i];
                end
                m_reg <= vmax;
            end
            S_NORM:
            begin
                // shift one place toward [2^29, 2^30); right shifts truncate
                if (m_reg[DIFF_W-1:30] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                idx_reg <= '0;
                acc_reg <= '0;
            end
            S_SQACC:
            begin
                acc_reg <= acc_reg + prod_reg[63:0];
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 1'b1;
                if (idx_reg == 2'd2)
                begin
                    sq_n_reg    <= acc_reg + prod_reg[63:0];
                    sq_res_reg  <= '0;
                    sq_bit_reg  <= 64'h4000_0000_0000_0000;
                    sq_acos_reg <= 1'b0;
                end
            end
            S_SQRT:
            begin
                sq_n_reg   <= sq_n_step;
                sq_res_reg <= sq_res_step;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_DIVINIT:
            begin
                len_reg <= sq_res_reg[31:0];
                rem_reg <= {3'b0, mag_reg[idx_reg][29:1]};
                dq_reg  <= {mag_reg[idx_reg][0], 30'b0};
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= dv_ge ? (dv_t - len_reg) : dv_t;
                dq_reg  <= {dq_reg[29:0], dv_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_DIVEND:
            begin
                if (vec_reg)
                begin
                    ub_reg[idx_reg] <= u_new;
                end
                else
                begin
                    ua_reg[idx_reg] <= u_new;
                end
                if (idx_reg == 2'd2)
                begin
                    idx_reg <= '0;
                    vec_reg <= 1'b1;
                    dot_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_DOTACC:
            begin
                dot_reg <= dot_reg + prod_reg[63:0];
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 1'b1;
            end
            S_COS:
            begin
                cneg_reg <= cclamp[33];
                x_reg    <= cclamp[33] ? 31'(-cclamp) : cclamp[30:0];
                p_reg    <= acos_coef(3'd7);
                k_reg    <= 3'd6;
            end
            S_HADD:
            begin
                p_reg <= qm[32:0] + acos_coef(k_reg);
                k_reg <= k_reg - 1'b1;
                if (k_reg == 3'd0)
                begin
                    sq_n_reg    <= {33'b0, ONE_Q30 - x_reg} << 30;
                    sq_res_reg  <= '0;
                    sq_bit_reg  <= 64'h4000_0000_0000_0000;
                    sq_acos_reg <= 1'b1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign empty          = !out_valid_reg;
    assign curve_index    = out_index_reg;
    assign total_rotation = out_rot_reg;
    assign is_interesting = out_int_reg;

endmodule
`default_nettype wire

/* rtl/polyline_turning_angle_sum_unit.sv */
// Top level of the polyline turning angle sum unit.
`default_nettype none
// Points of 3D curves arrive one per beat as signed Q16.16 coordinates; the
// beat with last_point set closes a curve and, once its angle is done, one
// result beat leaves with the curve number, the saturating Q16.16 sum of the
// turning angles and the threshold flag. A front stage keeps the two
// previous points and forms both segment vectors at accept time; a two-entry
// job queue hands them to a serial angle engine, so push can proceed while
// the engine works and a result waits in the output register. Points that
// start a curve skip the angle work; an angle uses 32-step square roots (one
// per segment, one in the arccosine), a radix-2 divider (31 steps per unit
// component, six components) and up to 29 normalizing shifts per segment.
// One registered 33x33 multiplier forms all products. The threshold resets
// to 823550 (about 4 pi); the user must write it through cfg_we/cfg_wdata
// only while idle; the block does not enforce this.
module polyline_turning_angle_sum_unit #(
    parameter int unsigned MAX_POINTS = ptas_pkg::MAX_POINTS_DEF,
    parameter int unsigned MAX_CURVES = ptas_pkg::MAX_CURVES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  coord_x,
    input  wire logic signed [31:0]  coord_y,
    input  wire logic signed [31:0]  coord_z,
    input  wire logic                last_point,
    output logic                     empty,
    input  wire logic                pop,
    output logic [19:0]              curve_index,
    output logic [31:0]              total_rotation,
    output logic                     is_interesting,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata
);
    import ptas_pkg::*;

    logic        accept;
    logic        fifo_empty;
    logic        job_pop;
    job_t        front_job;
    job_t        back_job;
    logic [31:0] threshold_reg;

    // Take a point whenever the job queue has room.
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    ptas_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .last_point (last_point),
        .job        (front_job)
    );

    ptas_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_job),
        .rd_en    (job_pop),
        .rd_data  (back_job),
        .is_full  (full),
        .is_empty (fifo_empty)
    );

    ptas_back #(
        .MAX_CURVES (MAX_CURVES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job            (back_job),
        .job_valid      (!fifo_empty),
        .job_pop        (job_pop),
        .threshold      (threshold_reg),
        .pop            (pop),
        .empty          (empty),
        .curve_index    (curve_index),
        .total_rotation (total_rotation),
        .is_interesting (is_interesting)
    );

endmodule
`default_nettype wire

/* sim/tb_polyline_turning_angle_sum_unit.sv */
// Testbench for the polyline turning angle sum unit: directed table plus random curves.
`timescale 1ns / 100ps
`default_nettype none

// Points go in through a push/full queue port, one per beat. Results come out
// through an empty/pop queue port. Every accepted point runs through a local
// fixed-point model of the turning angle arithmetic. Each point marked last
// queues one expected curve result. Popped results are checked field by field
// against the oldest queued one. The stimulus runs in this order:
//   - a short directed table: coordinate extremes, short curves, a straight
//     line, a reversal and zero-length segments;
//   - random curves under several thresholds, with a long receiver hold-off.
module tb_polyline_turning_angle_sum_unit;

    import ptas_pkg::*;

    localparam int     MAX_PTS    = 4096;
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_PI     = 64'sd3373259426;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     SETTLE     = 600;
    localparam int     HOLD_LEN   = 6000;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;

    typedef longint vec3_t [3];

    typedef struct {
        logic [19:0] idx;
        logic [31:0] rot;
        logic        flag;
    } curve_result_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        lp;
        logic        chk;     // the result of this row is typed in below
        logic [19:0] idx;
        logic [31:0] rot;
        logic        flag;
    } dir_row_t;

    // Expected values are typed in only for rows that close a curve with an
    // obvious outcome; other rows rely on the model.
    dir_row_t dir_rows [0:19] = '{
        '{C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 20'd0, 32'd0, 1'b0},        // single point
        '{C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, 20'd1, 32'd0, 1'b0},        // two points
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd1, 32'd0, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd2, 32'd0, 32'd0, 1'b1, 1'b1, 20'd2, 32'd0, 1'b0},        // straight line
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd65536, 32'd0, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 20'd3, 32'd205887, 1'b0},   // reversal: pi
        '{32'd5, 32'd5, 32'd5, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd5, 32'd5, 32'd5, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd9, 32'd1, 32'hFFFF_FFFD, 1'b1, 1'b1, 20'd4, 32'd0, 1'b0}, // zero-length
        '{C_MAX, 32'd0, C_MIN, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{C_MIN, C_MAX, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{C_MAX, C_MIN, C_MAX, 1'b1, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd0, 32'd65536, 32'd0, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd0, 32'd65536, 32'hFFFF_0000, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'd1, 32'd2, 32'd3, 1'b0, 1'b0, 20'd0, 32'd0, 1'b0},
        '{32'hFFFF_FFF9, C_MAX, C_MIN, 1'b1, 1'b0, 20'd0, 32'd0, 1'b0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] coord_y = '0;
    logic signed [31:0] coord_z = '0;
    logic               last_point = 1'b0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               full, empty, is_interesting;
    logic [19:0]        curve_index;
    logic [31:0]        total_rotation;

    // Typed-in expectation that travels with the point beat.
    logic        row_chk = 1'b0;
    logic [19:0] row_idx = '0;
    logic [31:0] row_rot = '0;
    logic        row_flag = 1'b0;

    // Model state of the block.
    logic [31:0] prev_pts [6];
    int          pts_seen;
    logic [31:0] angle_acc;
    logic [19:0] curve_cnt;
    logic [31:0] thresh_q16;

    curve_result_t pending_curves [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  hold_req = 0;
    bit  tx_steady = 0;
    bit  rx_steady = 0;

    polyline_turning_angle_sum_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .last_point     (last_point),
        .empty          (empty),
        .pop            (pop),
        .curve_index    (curve_index),
        .total_rotation (total_rotation),
        .is_interesting (is_interesting),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, b;
        res = '0;
        b = 64'h1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint poly_coef(input int k);
        case (k)
            0:       return 64'sd1686629690;
            1:       return -64'sd230423709;
            2:       return 64'sd95540460;
            3:       return -64'sd53874249;
            4:       return 64'sd33169905;
            5:       return -64'sd18348235;
            6:       return 64'sd7161955;
            default: return -64'sd1355590;
        endcase
    endfunction

    // Normalize a segment to Q30 unit length; zero segments report 0.
    function automatic bit seg_unit(input vec3_t d, output vec3_t u);
        logic [63:0] mag [3];
        logic [63:0] m, n, len, q;
        int i;
        m = '0;
        n = '0;
        u = '{0, 0, 0};
        for (i = 0; i < 3; i++)
        begin
            mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 1'b0;
        while (m >= (64'h1 << 30))
        begin
            m = m >> 1;
            for (i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'h1 << 29))
        begin
            m = m << 1;
            for (i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (i = 0; i < 3; i++) n = n + mag[i] * mag[i];
        len = int_sqrt(n);
        for (i = 0; i < 3; i++)
        begin
            q = (mag[i] << 30) / len;
            u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // Arccosine of a Q30 cosine, returned in Q16.16 radians.
    function automatic logic [31:0] arc_cos_q16(input longint c);
        longint x, p, s, r;
        int k;
        x = c < 0 ? -c : c;
        p = poly_coef(7);
        for (k = 6; k >= 0; k--) p = (p * x) / Q30_ONE + poly_coef(k);
        s = longint'(int_sqrt(64'(Q30_ONE - x) << 30));
        r = (p * s) / Q30_ONE;
        if (c < 0) r = Q30_PI - r;
        if (r < 0) r = 0;
        return 32'((r + 8192) >>> 14);
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < 6; i++) prev_pts[i] = '0;
        pts_seen = 0;
        angle_acc = '0;
        curve_cnt = '0;
        thresh_q16 = THRESH_RESET;
    endfunction

    // Advance the model by one point; return 1 when it closes a curve.
    function automatic bit model_point(input logic [31:0] px, py, pz, input logic lp,
                                       output curve_result_t res);
        vec3_t p0, p1, p2, a, b, ua, ub;
        longint dot, c;
        logic [32:0] sum;
        p2 = '{longint'($signed(px)), longint'($signed(py)), longint'($signed(pz))};
        for (int i = 0; i < 3; i++)
        begin
            p0[i] = longint'($signed(prev_pts[i]));
            p1[i] = longint'($signed(prev_pts[3+i]));
        end
        res = '{'0, '0, 1'b0};
        if (pts_seen >= 2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a[i] = p1[i] - p0[i];
                b[i] = p2[i] - p1[i];
            end
            if (seg_unit(a, ua) && seg_unit(b, ub))
            begin
                dot = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
                c = dot / Q30_ONE;
                if (c > Q30_ONE) c = Q30_ONE;
                if (c < -Q30_ONE) c = -Q30_ONE;
                sum = {1'b0, angle_acc} + {1'b0, arc_cos_q16(c)};
                angle_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end
        prev_pts[0] = prev_pts[3];
        prev_pts[1] = prev_pts[4];
        prev_pts[2] = prev_pts[5];
        prev_pts[3] = px;
        prev_pts[4] = py;
        prev_pts[5] = pz;
        if (pts_seen < MAX_PTS - 1) pts_seen++;
        if (!lp) return 1'b0;
        res.idx = curve_cnt;
        res.rot = angle_acc;
        res.flag = angle_acc > thresh_q16;
        curve_cnt = curve_cnt + 1'b1;
        pts_seen = 0;
        angle_acc = '0;
        for (int i = 0; i < 6; i++) prev_pts[i] = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------- monitor

    // Sample at the falling edge: inputs and outputs are stable there, and a
    // beat seen here is taken at the next rising edge.
    always @(negedge clk)
    begin
        curve_result_t want;
        bit took;
        took = 0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                took = 1;
                if (model_point(coord_x, coord_y, coord_z, last_point, want))
                begin
                    // Replace the model result with the typed-in one.
                    if (row_chk) want = '{row_idx, row_rot, row_flag};
                    pending_curves = {pending_curves, want};
                end
            end
            if (pop && !empty)
            begin
                took = 1;
                if (pending_curves.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: idx=%0d rot=%0d flag=%0b",
                                 curve_index, total_rotation, is_interesting);
                end
                else
                begin
                    want = pending_curves.pop_front();
                    if (curve_index !== want.idx || total_rotation !== want.rot ||
                        is_interesting !== want.flag)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp idx=%0d rot=%0d flag=%0b, got idx=%0d rot=%0d flag=%0b",
                                     want.idx, want.rot, want.flag,
                                     curve_index, total_rotation, is_interesting);
                    end
                end
            end
            // Watchdog: end the run when nothing moves for too long.
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------ receiver

    // Pop with random stalls; on request hold off for a long stretch so the
    // queue fills up and full pushes back on the sender.
    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 999);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 0;
            end
            else if (rx_steady)
                pop <= 1'b1;
            else if (r < 15)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(20, 200)) @(posedge clk);
            end
            else
                pop <= (r < 700);
        end
    end

    // -------------------------------------------------------------- sender

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 70) return 0;
        if (r < 96) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Offer one point; return at the rising edge that takes it.
    task automatic send_point(input logic [31:0] px, py, pz, input logic lp,
                              input logic chk = 1'b0, input logic [19:0] ci = '0,
                              input logic [31:0] rot = '0, input logic fl = 1'b0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        coord_x <= px;
        coord_y <= py;
        coord_z <= pz;
        last_point <= lp;
        row_chk <= chk;
        row_idx <= ci;
        row_rot <= rot;
        row_flag <= fl;
        @(negedge clk);
        while (full)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Hold input until every expected result is out and the engine is quiet.
    task automatic drain();
        push <= 1'b0;
        while (pending_curves.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        thresh_q16 = v;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(input int style, input logic [31:0] prior);
        case (style)
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 262144)) - 32'd131072;
            2:       return ($urandom_range(0, 9) < 4) ? prior : 32'($urandom_range(0, 8191));
            default: return 32'($signed($urandom_range(0, 6)) - 3) << 16;
        endcase
    endfunction

    // Random curves: mostly short, some medium, a few of one or two points.
    task automatic run_curves(input int n_items);
        int sent, len, style;
        logic [31:0] px, py, pz;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) :
                  $urandom_range(3, 6);
            style = $urandom_range(0, 3);
            tx_steady = ($urandom_range(0, 7) == 0);
            rx_steady = ($urandom_range(0, 7) == 0);
            px = '0;
            py = '0;
            pz = '0;
            for (int j = 0; j < len; j++)
            begin
                px = rand_coord(style, px);
                py = rand_coord(style, py);
                pz = rand_coord(style, pz);
                send_point(px, py, pz, j == len - 1);
                sent++;
            end
        end
        tx_steady = 0;
        rx_steady = 0;
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset threshold.
        foreach (dir_rows[i])
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].lp,
                       dir_rows[i].chk, dir_rows[i].idx, dir_rows[i].rot,
                       dir_rows[i].flag);
        drain();

        set_threshold(32'd0);
        run_curves(300);
        drain();

        // Long receiver hold-off while the sender keeps offering points.
        set_threshold(32'hFFFF_FFFF);
        hold_req = 1;
        run_curves(300);
        drain();

        set_threshold(32'd205887);
        run_curves(300);
        drain();

        set_threshold($urandom_range(100000, 900000));
        run_curves(300);
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
